// File: hdl/rgb_to_hsv_converter_unit_defines.svh
// assertion macros used by the rgb to hsv converter unit
`ifndef RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// checked property, quiet while reset is applied
`define RHC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rhc assertion failed");

// checked property, also evaluated during reset
`define RHC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rhc assertion failed");

`else

`define RHC_ASSERT(lbl, clk, rst_n, prop)

`define RHC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: hdl/rhc_pkg.sv
// shared types and constants of the rgb to hsv converter
package rhc_pkg;

	// channel byte width
	localparam int BYTE_W = 8;
	// width of six times the channel spread (6 * 255 = 1530)
	localparam int D6_W = 11;
	// width of the hue numerator before scaling
	localparam int NUM_W = 12;
	// hue quotient width
	localparam int HUE_W = 16;
	// hue dividend width: num * 65535 < 1530 * 65535 < 2**27
	localparam int HUE_NW = 27;
	// saturation dividend width: d * 255 < 2**16
	localparam int SAT_NW = 16;
	// divider depth, one quotient bit per stage
	localparam int DIV_LAT = HUE_W;

	// which channel holds the maximum, red wins ties, then green
	typedef enum logic [2:0] {
		MAX_RED   = 3'b001,
		MAX_GREEN = 3'b010,
		MAX_BLUE  = 3'b100
	} max_sel_t;

	// fields that ride alongside the dividers
	typedef struct packed {
		logic [BYTE_W-1:0] alpha;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] bright;
	} side_t;

endpackage

// File: hdl/rhc_div.sv
// pipelined restoring divider, one quotient bit per register stage
module rhc_div #(
	parameter int NW = 27,
	parameter int DW = 11,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [QW-1:0] quotient
);

	// the quotient must fit in QW bits, so the remainder stays below divisor << QW
	localparam int CW = DW + QW;

	logic [CW-1:0] rem_s [QW];
	logic [DW-1:0] dvs_s [QW];
	logic [QW-1:0] quo_s [QW];

	generate
		for (genvar k = 0; k < QW; k++) begin : g_step
			localparam int SH = QW - 1 - k;
			logic [CW-1:0] rem_in;
			logic [DW-1:0] dvs_in;
			logic [QW-1:0] quo_in;
			logic [CW-1:0] trial;
			logic          fits;

			// stage inputs: the operands for the first step, the previous step otherwise
			if (k == 0) begin : g_first
				assign rem_in = CW'(dividend);
				assign dvs_in = divisor;
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign dvs_in = dvs_s[k-1];
				assign quo_in = quo_s[k-1];
			end

			// trial subtract of the shifted divisor
			always_comb begin
				trial = CW'(dvs_in) << SH;
				fits  = (rem_in >= trial);
			end

			// step register
			always_ff @(posedge clk) begin
				rem_s[k] <= fits ? (rem_in - trial) : rem_in;
				dvs_s[k] <= dvs_in;
				quo_s[k] <= {quo_in[QW-2:0], fits};
			end
		end
	endgenerate

	assign quotient = quo_s[QW-1];

endmodule

// File: hdl/rgb_to_hsv_converter_unit.sv
// rgb to hsv converter: unpacks a colour word and converts it to hue, saturation, brightness
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy is always
//   low, so a new colour word may be offered on packed_color in every cycle.
//   Each result is shown for exactly one cycle with done high: the unpacked red,
//   green, blue and alpha bytes, hue (a full turn scaled to 65535), saturation
//   (0..255) and brightness (the largest channel).
//   A request passes three stages of unpacking, extremum search and operand set-up,
//   sixteen stages of the hue and saturation dividers (one quotient bit each) and
//   one output stage before its result appears with done high.
//   Throughput is one colour word per cycle; the sixteen-step divider pipelines
//   set the depth, not the rate.
//   The receiver cannot stall: results leave on their fixed cycle and must be
//   taken then.
//   Reset (arst_n low) clears every valid bit at once; items in flight are
//   dropped and done stays low until new requests come through.
`include "rgb_to_hsv_converter_unit_defines.svh"

module rgb_to_hsv_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] packed_color,
	output logic        done,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [15:0] hue,
	output logic [7:0]  saturation,
	output logic [7:0]  brightness
);

	localparam int LAT = 4 + rhc_pkg::DIV_LAT;

	// stage 1: unpacked bytes
	logic                        vld_s1;
	logic [rhc_pkg::BYTE_W-1:0]  a_s1, r_s1, g_s1, b_s1;

	// stage 2: extremes and the winning channel
	logic                        vld_s2;
	logic [rhc_pkg::BYTE_W-1:0]  a_s2, r_s2, g_s2, b_s2, mx_s2, d_s2;
	rhc_pkg::max_sel_t           sel_s2;

	// stage 3: divider operands
	logic                        vld_s3;
	rhc_pkg::side_t              side_s3;
	logic [rhc_pkg::HUE_NW-1:0]  hue_n_s3;
	logic [rhc_pkg::D6_W-1:0]    hue_d_s3;
	logic [rhc_pkg::SAT_NW-1:0]  sat_n_s3;
	logic [rhc_pkg::BYTE_W-1:0]  sat_d_s3;

	// divider stages: side fields and valid bits keep pace
	logic                        vld_div_s [rhc_pkg::DIV_LAT];
	rhc_pkg::side_t              side_div_s [rhc_pkg::DIV_LAT];
	logic [rhc_pkg::HUE_W-1:0]   hue_quo;
	logic [rhc_pkg::HUE_W-1:0]   sat_quo;

	// output stage
	logic                        vld_s20;
	rhc_pkg::side_t              side_s20;
	logic [rhc_pkg::HUE_W-1:0]   hue_s20;
	logic [rhc_pkg::BYTE_W-1:0]  sat_s20;

	// combinational helpers
	logic [rhc_pkg::BYTE_W-1:0]  mx_c, mn_c;
	rhc_pkg::max_sel_t           sel_c;
	logic [rhc_pkg::D6_W-1:0]    d6_c;
	logic [rhc_pkg::NUM_W-1:0]   num_c;
	logic [rhc_pkg::D6_W-1:0]    num_u_c;

	// no back-pressure: a request is taken every cycle
	assign busy = 1'b0;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s20 <= 1'b0;
			for (int k = 0; k < rhc_pkg::DIV_LAT; k++) begin
				vld_div_s[k] <= 1'b0;
			end
		end else begin
			vld_s1       <= start & ~busy;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_div_s[0] <= vld_s3;
			for (int k = 1; k < rhc_pkg::DIV_LAT; k++) begin
				vld_div_s[k] <= vld_div_s[k-1];
			end
			vld_s20 <= vld_div_s[rhc_pkg::DIV_LAT-1];
		end
	end

	// stage 1: unpack the colour word
	always_ff @(posedge clk) begin
		a_s1 <= packed_color[31:24];
		r_s1 <= packed_color[23:16];
		g_s1 <= packed_color[15:8];
		b_s1 <= packed_color[7:0];
	end

	// largest and smallest channel, red first on ties, then green
	always_comb begin
		mx_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		mn_c = r_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;
		if (mx_c == r_s1) begin
			sel_c = rhc_pkg::MAX_RED;
		end else if (mx_c == g_s1) begin
			sel_c = rhc_pkg::MAX_GREEN;
		end else begin
			sel_c = rhc_pkg::MAX_BLUE;
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		a_s2   <= a_s1;
		r_s2   <= r_s1;
		g_s2   <= g_s1;
		b_s2   <= b_s1;
		mx_s2  <= mx_c;
		d_s2   <= mx_c - mn_c;
		sel_s2 <= sel_c;
	end

	// hue numerator, within [0, 6d) for nonzero d and zero for grey
	always_comb begin
		d6_c = rhc_pkg::D6_W'(d_s2) * rhc_pkg::D6_W'(6);
		case (sel_s2)
			rhc_pkg::MAX_RED: begin
				num_c = rhc_pkg::NUM_W'(g_s2) - rhc_pkg::NUM_W'(b_s2);
				if (g_s2 < b_s2) num_c = num_c + rhc_pkg::NUM_W'(d6_c);
			end
			rhc_pkg::MAX_GREEN: begin
				num_c = rhc_pkg::NUM_W'(b_s2) - rhc_pkg::NUM_W'(r_s2)
					+ (rhc_pkg::NUM_W'(d_s2) << 1);
			end
			rhc_pkg::MAX_BLUE: begin
				num_c = rhc_pkg::NUM_W'(r_s2) - rhc_pkg::NUM_W'(g_s2)
					+ (rhc_pkg::NUM_W'(d_s2) << 2);
			end
			default: begin
				num_c = '0;
			end
		endcase
		num_u_c = num_c[rhc_pkg::D6_W-1:0];
	end

	// stage 3: scaled dividends; a zero divisor becomes one, its dividend is zero then
	always_ff @(posedge clk) begin
		side_s3.alpha  <= a_s2;
		side_s3.red    <= r_s2;
		side_s3.green  <= g_s2;
		side_s3.blue   <= b_s2;
		side_s3.bright <= mx_s2;
		hue_n_s3 <= (rhc_pkg::HUE_NW'(num_u_c) << rhc_pkg::HUE_W) - rhc_pkg::HUE_NW'(num_u_c);
		hue_d_s3 <= (d_s2 == '0) ? rhc_pkg::D6_W'(1) : d6_c;
		sat_n_s3 <= (rhc_pkg::SAT_NW'(d_s2) << rhc_pkg::BYTE_W) - rhc_pkg::SAT_NW'(d_s2);
		sat_d_s3 <= (mx_s2 == '0) ? rhc_pkg::BYTE_W'(1) : mx_s2;
	end

	// hue divider
	rhc_div #(
		.NW (rhc_pkg::HUE_NW),
		.DW (rhc_pkg::D6_W),
		.QW (rhc_pkg::HUE_W)
	) u_hue_div (
		.clk      (clk),
		.dividend (hue_n_s3),
		.divisor  (hue_d_s3),
		.quotient (hue_quo)
	);

	// saturation divider, same depth so both quotients line up
	rhc_div #(
		.NW (rhc_pkg::SAT_NW),
		.DW (rhc_pkg::BYTE_W),
		.QW (rhc_pkg::HUE_W)
	) u_sat_div (
		.clk      (clk),
		.dividend (sat_n_s3),
		.divisor  (sat_d_s3),
		.quotient (sat_quo)
	);

	// side fields delayed alongside the dividers
	always_ff @(posedge clk) begin
		side_div_s[0] <= side_s3;
		for (int k = 1; k < rhc_pkg::DIV_LAT; k++) begin
			side_div_s[k] <= side_div_s[k-1];
		end
	end

	// output stage
	always_ff @(posedge clk) begin
		side_s20 <= side_div_s[rhc_pkg::DIV_LAT-1];
		hue_s20  <= hue_quo;
		sat_s20  <= sat_quo[rhc_pkg::BYTE_W-1:0];
	end

	assign done       = vld_s20;
	assign red        = side_s20.red;
	assign green      = side_s20.green;
	assign blue       = side_s20.blue;
	assign alpha      = side_s20.alpha;
	assign hue        = hue_s20;
	assign saturation = sat_s20;
	assign brightness = side_s20.bright;

	// every request comes out after the fixed latency
	`RHC_ASSERT(a_latency, clk, arst_n, (start && !busy) |-> ##LAT done)
	// brightness is the largest channel
	`RHC_ASSERT(a_bright_max, clk, arst_n, done |-> (brightness >= red && brightness >= green && brightness >= blue))
	// saturation is zero exactly for grey and black
	`RHC_ASSERT(a_sat_zero, clk, arst_n, done |-> ((saturation == 8'd0) == (red == green && green == blue)))
	// grey has no hue
	`RHC_ASSERT(a_grey_hue, clk, arst_n, (done && red == green && green == blue) |-> (hue == 16'd0))
	// nothing leaves while reset holds the pipeline empty
	`RHC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !done)

endmodule

// File: verif/tb_rgb_to_hsv_converter_unit.sv
// self-checking testbench for the rgb to hsv converter, predicting each result from the colour word
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;

	// one converted colour as it leaves the block
	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] packed_color;
	logic        done;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [15:0] hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;

	logic [31:0] colour_word_q[$];
	hsv_result_t pending_hsv_q[$];
	logic        req_taken;
	int unsigned idle_pct;
	int unsigned mismatch_count;

	rgb_to_hsv_converter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.packed_color (packed_color),
		.done         (done),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.hue          (hue),
		.saturation   (saturation),
		.brightness   (brightness)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected conversion of one colour word
	function automatic hsv_result_t convert_colour(input logic [31:0] word);
		hsv_result_t       res;
		logic [7:0]        r;
		logic [7:0]        g;
		logic [7:0]        b;
		logic [7:0]        hi;
		logic [7:0]        lo;
		rhc_pkg::max_sel_t winner;
		int unsigned       spread;
		int unsigned       num;
		r = word[23:16];
		g = word[15:8];
		b = word[7:0];
		// red wins ties, then green
		if (r >= g && r >= b) begin
			winner = rhc_pkg::MAX_RED;
			hi = r;
		end else if (g >= b) begin
			winner = rhc_pkg::MAX_GREEN;
			hi = g;
		end else begin
			winner = rhc_pkg::MAX_BLUE;
			hi = b;
		end
		lo = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		spread = hi - lo;
		res.red = r;
		res.green = g;
		res.blue = b;
		res.alpha = word[31:24];
		res.brightness = hi;
		// black has no saturation
		res.saturation = (hi != 0) ? 8'((spread * 255) / hi) : 8'd0;
		// grey has no hue; the numerator always stays in [0, 6 * spread)
		if (spread == 0) begin
			res.hue = 16'd0;
		end else begin
			case (winner)
				rhc_pkg::MAX_RED:   num = (g >= b) ? g - b : 6 * spread + g - b;
				rhc_pkg::MAX_GREEN: num = 2 * spread + b - r;
				default:            num = 4 * spread + r - g;
			endcase
			res.hue = 16'((num * 65535) / (6 * spread));
		end
		return res;
	endfunction

	// random colour word, biased towards greys, ties and channel extremes
	function automatic logic [31:0] random_colour_word();
		logic [31:0] word;
		logic [7:0]  v;
		word = $urandom;
		v = $urandom_range(0, 255);
		case ($urandom_range(0, 7))
			0: word[23:0] = {v, v, v};
			1: word[23:8] = {v, v};
			2: word[15:0] = {v, v};
			3: word[23:16] = word[7:0];
			4: begin
				word[23:16] = v;
				word[15:8] = v - 8'($urandom_range(0, 2));
				word[7:0] = v - 8'($urandom_range(0, 2));
			end
			5: word[23:0] = {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
				8'($urandom_range(0, 1) * 255)};
			default: ;
		endcase
		return word;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t ns: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// wait until every queued request is taken and every result has come back
	task automatic drain_requests();
		while (colour_word_q.size() != 0 || start || pending_hsv_q.size() != 0)
			@(negedge clk);
	endtask

	// driver: offers the next colour word unless idling, changes on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || req_taken) begin
			if (colour_word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				packed_color <= colour_word_q.pop_front();
				start <= 1'b1;
			end else begin
				packed_color <= $urandom;
				start <= 1'b0;
			end
		end
	end

	// monitor: checks results against the oldest prediction and records taken requests
	always @(posedge clk or negedge arst_n) begin
		hsv_result_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			if (done) begin
				if (pending_hsv_q.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = pending_hsv_q.pop_front();
					check_field("red", red, want.red);
					check_field("green", green, want.green);
					check_field("blue", blue, want.blue);
					check_field("alpha", alpha, want.alpha);
					check_field("hue", hue, want.hue);
					check_field("saturation", saturation, want.saturation);
					check_field("brightness", brightness, want.brightness);
				end
			end
			if (start && !busy)
				pending_hsv_q = {pending_hsv_q, convert_colour(packed_color)};
			req_taken <= start && !busy;
		end
	end

	// overall time limit
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stimulus and end of run
	initial begin
		clk = 1'b0;
		arst_n = 1'b1;
		start = 1'b0;
		packed_color = 32'd0;
		idle_pct = 0;
		mismatch_count = 0;
		// reset falls after time zero so the asynchronous clear is seen
		#1 arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed colours: black, white, primaries, ties, greys, red hue wrap
		colour_word_q = '{
			32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_FFFF,
			32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'h80FF_FF00,
			32'h8000_FFFF, 32'h80FF_00FF, 32'h0080_8080, 32'h0001_0101,
			32'h00FF_0010, 32'h00FF_1000, 32'h0001_0000, 32'h0000_0001,
			32'h00FE_FFFE, 32'h00FF_FEFF, 32'h0001_0001, 32'h5555_AAAA,
			32'hAAAA_5555, 32'h00FF_FEFD, 32'h00FD_FEFF
		};
		drain_requests();

		// sender idles rarely, then often, then never; each phase drains fully
		idle_pct = 13;
		repeat (650) colour_word_q = {colour_word_q, random_colour_word()};
		drain_requests();
		idle_pct = 83;
		repeat (650) colour_word_q = {colour_word_q, random_colour_word()};
		drain_requests();
		idle_pct = 0;
		repeat (650) colour_word_q = {colour_word_q, random_colour_word()};
		drain_requests();

		repeat (30) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: rgb_to_hsv_converter_unit.f
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rhc_div.sv
hdl/rgb_to_hsv_converter_unit.sv
verif/tb_rgb_to_hsv_converter_unit.sv
